// ===== src/scr_pkg.sv =====
`timescale 1ns / 1ps
// scr_pkg: shared types and constants for the scalar rainbow colormap.
// No dependencies; used by the interfaces, the divider step and the top level.
package scr_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int QUO_W      = FRAC_BITS + 2;
  localparam int DIV_STAGES = QUO_W;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] CH_FULL      = 8'hFF;
  localparam logic [7:0] CH_ZERO      = 8'h00;

  localparam logic signed [DATA_W-1:0] RANGE_MIN_RST = 32'sd0;
  localparam logic signed [DATA_W-1:0] RANGE_MAX_RST = 32'sd65536;
  localparam logic signed [DATA_W-1:0] EMPTY_THR_RST = -32'sd255999744;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_MIN = 2'd0,
    REG_RANGE_MAX = 2'd1,
    REG_EMPTY_THR = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_EMPTY = 2'd0,
    KIND_RED   = 2'd1,
    KIND_BLUE  = 2'd2,
    KIND_RAMP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    SEG_RED_YEL = 2'd0,
    SEG_YEL_GRN = 2'd1,
    SEG_GRN_CYN = 2'd2,
    SEG_CYN_BLU = 2'd3
  } seg_t;

  typedef struct packed {
    kind_t              kind;
    logic [DATA_W-1:0]  rem;
    logic [DATA_W-1:0]  den;
    logic [QUO_W-1:0]   quo;
  } pipe_t;

endpackage

// ===== src/scr_if.sv =====
`timescale 1ns / 1ps
// scr_in_if / scr_out_if: valid-ready channels of the colormap core.
// Depends on scr_pkg for field widths.
interface scr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [scr_pkg::DATA_W-1:0]  sample_val;

  modport source (output valid, output sample_val, input ready);
  modport sink   (input valid, input sample_val, output ready);
endinterface

interface scr_out_if;
  logic                         valid;
  logic                         ready;
  logic [scr_pkg::DATA_W-1:0]   argb;
  logic                         is_empty;

  modport source (output valid, output argb, output is_empty, input ready);
  modport sink   (input valid, input argb, input is_empty, output ready);
endinterface

// ===== src/scr_div_step.sv =====
`timescale 1ns / 1ps
// scr_div_step: one restoring-division stage, yields one quotient bit per beat.
// Depends on scr_pkg (pipe_t).
module scr_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           in_valid,
  input  scr_pkg::pipe_t in_data,
  output logic           out_valid,
  output scr_pkg::pipe_t out_data
);

  logic                        valid_r;
  scr_pkg::pipe_t              data_r;
  scr_pkg::pipe_t              data_nxt;
  logic [scr_pkg::DATA_W:0]    rem2;
  logic [scr_pkg::DATA_W+1:0]  diff;
  logic                        ge;

  always_comb begin
    rem2     = {in_data.rem, 1'b0};
    diff     = {1'b0, rem2} - {2'b00, in_data.den};
    ge       = ~diff[scr_pkg::DATA_W+1];
    data_nxt = in_data;
    // keep the partial remainder below the divisor
    data_nxt.rem = ge ? diff[scr_pkg::DATA_W-1:0] : rem2[scr_pkg::DATA_W-1:0];
    data_nxt.quo = {in_data.quo[scr_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== src/scalar_rainbow_colormap_core.sv =====
`timescale 1ns / 1ps
// scalar_rainbow_colormap_core: top level, sample to ARGB rainbow color.
// Depends on scr_pkg, scr_in_if / scr_out_if and scr_div_step.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        sample_val[31:0] signed Q23.8
//   out_ch   out  valid/ready        argb[31:0], is_empty
//   cfg_*    in   cfg_we             cfg_index[1:0], cfg_wdata[31:0]
//
// One beat accepted per cycle while out_ch takes results; the stages are a
// compare/subtract stage, one restoring-division stage per quotient bit,
// and a ramp/pack stage into the output register.
// rst_n is synchronous; it clears valid bits and loads register defaults.
// Each stage holds only when its successor is full and held, so bubbles close
// up and input is taken while a result waits on out_ch if any stage is empty.
module scalar_rainbow_colormap_core (
  input  logic                          clk,
  input  logic                          rst_n,
  scr_in_if.sink                        in_ch,
  scr_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [scr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scr_pkg::DATA_W-1:0]    cfg_wdata
);

  localparam int NS = scr_pkg::DIV_STAGES;

  logic signed [scr_pkg::DATA_W-1:0] range_min_r;
  logic signed [scr_pkg::DATA_W-1:0] range_max_r;
  logic signed [scr_pkg::DATA_W-1:0] empty_thr_r;

  logic                  stage_v   [0:NS];
  scr_pkg::pipe_t        stage_d   [0:NS];
  logic [NS+1:0]         adv;

  scr_pkg::pipe_t        pre_nxt;
  logic [scr_pkg::DATA_W:0] num_wide;
  logic [scr_pkg::DATA_W:0] den_wide;

  logic                        out_valid_r;
  logic [scr_pkg::DATA_W-1:0]  argb_r;
  logic [scr_pkg::DATA_W-1:0]  argb_nxt;
  logic                        is_empty_r;
  logic                        is_empty_nxt;

  logic [scr_pkg::FRAC_BITS-1:0] frac;
  logic [scr_pkg::FRAC_BITS+7:0] prod;
  logic [7:0]                    ramp;
  scr_pkg::seg_t                 seg;
  scr_pkg::pipe_t                last_d;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_min_r <= scr_pkg::RANGE_MIN_RST;
      range_max_r <= scr_pkg::RANGE_MAX_RST;
      empty_thr_r <= scr_pkg::EMPTY_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scr_pkg::REG_RANGE_MIN: range_min_r <= cfg_wdata;
        scr_pkg::REG_RANGE_MAX: range_max_r <= cfg_wdata;
        scr_pkg::REG_EMPTY_THR: empty_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance chain: a stage moves when it is empty or its successor moves
  assign adv[NS+1] = ~out_valid_r | out_ch.ready;
  genvar gi;
  generate
    for (gi = 0; gi <= NS; gi++) begin : g_adv
      assign adv[gi] = ~stage_v[gi] | adv[gi+1];
    end
  endgenerate

  assign in_ch.ready = adv[0];

  // classify the sample and set up the division
  always_comb begin
    num_wide = {range_max_r[scr_pkg::DATA_W-1], range_max_r}
             - {in_ch.sample_val[scr_pkg::DATA_W-1], in_ch.sample_val};
    den_wide = {range_max_r[scr_pkg::DATA_W-1], range_max_r}
             - {range_min_r[scr_pkg::DATA_W-1], range_min_r};
    pre_nxt.rem = num_wide[scr_pkg::DATA_W-1:0];
    pre_nxt.den = den_wide[scr_pkg::DATA_W-1:0];
    pre_nxt.quo = '0;
    if (in_ch.sample_val <= empty_thr_r) begin
      pre_nxt.kind = scr_pkg::KIND_EMPTY;
    end else if (in_ch.sample_val >= range_max_r) begin
      pre_nxt.kind = scr_pkg::KIND_RED;
    end else if (in_ch.sample_val <= range_min_r) begin
      pre_nxt.kind = scr_pkg::KIND_BLUE;
    end else begin
      pre_nxt.kind = scr_pkg::KIND_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v[0] <= 1'b0;
    end else if (adv[0]) begin
      stage_v[0] <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      stage_d[0] <= pre_nxt;
    end
  end

  generate
    for (gi = 1; gi <= NS; gi++) begin : g_div
      scr_div_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv[gi]),
        .in_valid (stage_v[gi-1]),
        .in_data  (stage_d[gi-1]),
        .out_valid(stage_v[gi]),
        .out_data (stage_d[gi])
      );
    end
  endgenerate

  // ramp = floor(frac * 255 / 2^FRAC_BITS), then pick the segment
  always_comb begin
    last_d = stage_d[NS];
    frac   = last_d.quo[scr_pkg::FRAC_BITS-1:0];
    prod   = {frac, 8'h00} - {8'h00, frac};
    ramp   = prod[scr_pkg::FRAC_BITS+7:scr_pkg::FRAC_BITS];
    seg    = scr_pkg::seg_t'(last_d.quo[scr_pkg::QUO_W-1:scr_pkg::QUO_W-2]);
    is_empty_nxt = 1'b0;
    case (last_d.kind)
      scr_pkg::KIND_EMPTY: begin
        argb_nxt     = '0;
        is_empty_nxt = 1'b1;
      end
      scr_pkg::KIND_RED:
        argb_nxt = {scr_pkg::ALPHA_OPAQUE, scr_pkg::CH_FULL, scr_pkg::CH_ZERO,
                    scr_pkg::CH_ZERO};
      scr_pkg::KIND_BLUE:
        argb_nxt = {scr_pkg::ALPHA_OPAQUE, scr_pkg::CH_ZERO, scr_pkg::CH_ZERO,
                    scr_pkg::CH_FULL};
      default: begin
        case (seg)
          scr_pkg::SEG_RED_YEL:
            argb_nxt = {scr_pkg::ALPHA_OPAQUE, scr_pkg::CH_FULL, ramp,
                        scr_pkg::CH_ZERO};
          scr_pkg::SEG_YEL_GRN:
            argb_nxt = {scr_pkg::ALPHA_OPAQUE, scr_pkg::CH_FULL - ramp,
                        scr_pkg::CH_FULL, scr_pkg::CH_ZERO};
          scr_pkg::SEG_GRN_CYN:
            argb_nxt = {scr_pkg::ALPHA_OPAQUE, scr_pkg::CH_ZERO, scr_pkg::CH_FULL,
                        ramp};
          default:
            argb_nxt = {scr_pkg::ALPHA_OPAQUE, scr_pkg::CH_ZERO,
                        scr_pkg::CH_FULL - ramp, scr_pkg::CH_FULL};
        endcase
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv[NS+1]) begin
      out_valid_r <= stage_v[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS+1]) begin
      argb_r     <= argb_nxt;
      is_empty_r <= is_empty_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.argb     = argb_r;
  assign out_ch.is_empty = is_empty_r;

endmodule
